### rtl/dhkv_pkg.sv
// ----------------------------------------------------------------------------
// dhkv_pkg: shared types and constants for the double-hash key/value table
// Slot geometry, hash multipliers, operation and status codes.
// ----------------------------------------------------------------------------
package dhkv_pkg;

    localparam int SLOT_W = 10;                    // log2 of the slot store depth
    localparam int SLOTS  = 1 << SLOT_W;
    localparam int LOG_W  = $clog2(SLOT_W + 1);    // width of a clamped log2
    localparam int CFG_W  = 4;
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int FRAC_W = 16;

    localparam logic [FRAC_W-1:0] GOLDEN_MULT = 16'd40503;
    localparam logic [31:0]       STRIDE_MULT = 32'd134217689;

    localparam logic [CFG_W-1:0]  LOG_RESET = 4'd10;
    localparam logic [LOG_W-1:0]  LOG_MIN   = LOG_W'(2);
    localparam logic [LOG_W-1:0]  LOG_MAX   = LOG_W'(SLOT_W);

    localparam logic [OP_W-1:0] OP_SET    = 2'd0;
    localparam logic [OP_W-1:0] OP_GET    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

    typedef struct packed {
        logic [SLOT_W-1:0] start;
        logic [SLOT_W-1:0] stride;
    } hash_t;

endpackage

### rtl/dhkv_ram.sv
// ----------------------------------------------------------------------------
// dhkv_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dhkv_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/dhkv_hash.sv
// ----------------------------------------------------------------------------
// dhkv_hash: start slot and probe stride for a key
// Multiplicative start slot from the top bits of a 16-bit fraction, odd stride.
// ----------------------------------------------------------------------------
module dhkv_hash (
    input  logic [dhkv_pkg::KEY_W-1:0]  key,
    input  logic [dhkv_pkg::LOG_W-1:0]  log2_size,
    input  logic [dhkv_pkg::SLOT_W-1:0] mask,
    output dhkv_pkg::hash_t             hash
);

    logic [dhkv_pkg::KEY_W-3:0]  k;
    logic [dhkv_pkg::FRAC_W-1:0] frac;
    logic [dhkv_pkg::FRAC_W-1:0] start_full;
    logic [dhkv_pkg::SLOT_W-1:0] stride_raw;

    assign k    = key[dhkv_pkg::KEY_W-1:2];
    assign frac = dhkv_pkg::FRAC_W'(k[dhkv_pkg::FRAC_W-1:0] * dhkv_pkg::GOLDEN_MULT);

    // size * frac >> 16 with size a power of two: keep the top log2 bits
    assign start_full = frac >> (dhkv_pkg::FRAC_W - int'(log2_size));

    assign stride_raw = dhkv_pkg::SLOT_W'(k[dhkv_pkg::SLOT_W-1:0]
                        * dhkv_pkg::STRIDE_MULT[dhkv_pkg::SLOT_W-1:0]);

    assign hash.start  = start_full[dhkv_pkg::SLOT_W-1:0] & mask;
    assign hash.stride = (stride_raw & mask) | dhkv_pkg::SLOT_W'(1);

endmodule

### rtl/double_hash_key_value_table_core.sv
// ----------------------------------------------------------------------------
// double_hash_key_value_table_core: open-addressing key/value table
// Set, get and remove of 32-bit keys over double-hashed probing of two
// synchronous slot memories (keys and values).
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  s_axis   | in        | s_axis_tvalid/tready    | tuser: op; tdata: key, value
//  m_axis   | out       | m_axis_tvalid/tready    | tuser: status; tdata: found_value
//  cfg      | in        | cfg_wr_en               | cfg_wr_data: table_log2
//
//  An item is accepted, hashed and read, then compared once per slot probed, up to
//  2^table_log2 slots (table_log2 clamped to 2..10); one item is taken at a time.
//  An unknown op finishes in its hash state, without a memory read.
//  After reset both memories are cleared slot by slot; no item is taken then.
//  A finished result waits in the output register; a stalled output holds the
//  next finished result in a holding register until the first one is taken.
// ----------------------------------------------------------------------------
module double_hash_key_value_table_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [dhkv_pkg::OP_W-1:0]     s_axis_tuser,   // [1:0] op
    input  logic [63:0]                   s_axis_tdata,   // [31:0] key, [63:32] value
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [dhkv_pkg::STAT_W-1:0]   m_axis_tuser,   // [1:0] status
    output logic [31:0]                   m_axis_tdata,   // [31:0] found_value
    input  logic                          cfg_wr_en,
    input  logic [dhkv_pkg::CFG_W-1:0]    cfg_wr_data     // table_log2
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_HASH  = 6'b000100,
        ST_READ  = 6'b001000,
        ST_CHECK = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                        state_reg, state_next;
    logic [dhkv_pkg::CFG_W-1:0]    log_cfg_reg;
    logic [dhkv_pkg::SLOT_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [dhkv_pkg::SLOT_W-1:0]   cnt_reg, cnt_next;
    logic [dhkv_pkg::SLOT_W-1:0]   h_reg, h_next;
    logic [dhkv_pkg::SLOT_W-1:0]   stride_reg, stride_next;
    logic [dhkv_pkg::OP_W-1:0]     op_reg;
    logic [dhkv_pkg::KEY_W-1:0]    key_reg;
    logic [dhkv_pkg::VAL_W-1:0]    val_reg;
    logic                          out_valid_reg;
    logic [dhkv_pkg::VAL_W-1:0]    out_val_reg;
    logic [dhkv_pkg::STAT_W-1:0]   out_st_reg;
    logic [dhkv_pkg::VAL_W-1:0]    res_val_reg;
    logic [dhkv_pkg::STAT_W-1:0]   res_st_reg;

    logic [dhkv_pkg::LOG_W-1:0]    log_cfg_w;
    logic [dhkv_pkg::LOG_W-1:0]    log2_size;
    logic [dhkv_pkg::SLOT_W:0]     size;
    logic [dhkv_pkg::SLOT_W-1:0]   mask;
    dhkv_pkg::hash_t               hash;
    logic [dhkv_pkg::SLOT_W-1:0]   step;

    logic                          rd_en;
    logic [dhkv_pkg::SLOT_W-1:0]   rd_addr;
    logic [dhkv_pkg::KEY_W-1:0]    rd_key;
    logic [dhkv_pkg::VAL_W-1:0]    rd_val;
    logic                          key_we, val_we;
    logic [dhkv_pkg::SLOT_W-1:0]   wr_addr;
    logic [dhkv_pkg::KEY_W-1:0]    wr_key;
    logic [dhkv_pkg::VAL_W-1:0]    wr_val;

    logic                          fin;
    logic [dhkv_pkg::VAL_W-1:0]    fin_val;
    logic [dhkv_pkg::STAT_W-1:0]   fin_st;
    logic                          out_free;
    logic                          key_hit;

    // clamp the slot count to the supported range
    assign log_cfg_w = dhkv_pkg::LOG_W'(log_cfg_reg);
    assign log2_size = (log_cfg_w < dhkv_pkg::LOG_MIN) ? dhkv_pkg::LOG_MIN :
                       (log_cfg_w > dhkv_pkg::LOG_MAX) ? dhkv_pkg::LOG_MAX : log_cfg_w;
    assign size      = (dhkv_pkg::SLOT_W+1)'(1) << log2_size;
    assign mask      = dhkv_pkg::SLOT_W'(size - (dhkv_pkg::SLOT_W+1)'(1));
    assign step      = (h_reg + stride_reg) & mask;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign key_hit       = (rd_key == key_reg);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_val_reg;
    assign m_axis_tuser  = out_st_reg;

    dhkv_hash u_hash (
        .key       (key_reg),
        .log2_size (log2_size),
        .mask      (mask),
        .hash      (hash)
    );

    dhkv_ram #(
        .ADDR_W (dhkv_pkg::SLOT_W),
        .DATA_W (dhkv_pkg::KEY_W)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (wr_addr),
        .wdata (wr_key),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_key)
    );

    dhkv_ram #(
        .ADDR_W (dhkv_pkg::SLOT_W),
        .DATA_W (dhkv_pkg::VAL_W)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (wr_addr),
        .wdata (wr_val),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_val)
    );

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        cnt_next     = cnt_reg;
        h_next       = h_reg;
        stride_next  = stride_reg;
        rd_en        = 1'b0;
        rd_addr      = h_reg;
        key_we       = 1'b0;
        val_we       = 1'b0;
        wr_addr      = h_reg;
        wr_key       = key_reg;
        wr_val       = val_reg;
        fin          = 1'b0;
        fin_val      = '0;
        fin_st       = dhkv_pkg::STAT_OK;

        case (state_reg)
            ST_CLEAR:
            begin
                key_we       = 1'b1;
                val_we       = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_key       = '0;
                wr_val       = '0;
                clr_cnt_next = clr_cnt_reg + dhkv_pkg::SLOT_W'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (op_reg == dhkv_pkg::OP_NONE)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    h_next      = hash.start;
                    stride_next = hash.stride;
                    cnt_next    = '0;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (op_reg == dhkv_pkg::OP_SET && (rd_val == '0 || key_hit))
                begin
                    key_we = 1'b1;
                    val_we = 1'b1;
                    fin    = 1'b1;
                end
                else if (op_reg != dhkv_pkg::OP_SET && rd_key == '0)
                begin
                    fin    = 1'b1;
                    fin_st = dhkv_pkg::STAT_NOT_FOUND;
                end
                else if (op_reg == dhkv_pkg::OP_GET && key_hit)
                begin
                    fin     = 1'b1;
                    fin_val = rd_val;
                    fin_st  = (rd_val != '0) ? dhkv_pkg::STAT_OK : dhkv_pkg::STAT_NOT_FOUND;
                end
                else if (op_reg == dhkv_pkg::OP_REMOVE && key_hit)
                begin
                    val_we = 1'b1;
                    wr_val = '0;
                    fin    = 1'b1;
                end
                else if (cnt_reg == mask)
                begin
                    // one full pass without a fit or a stop
                    fin    = 1'b1;
                    fin_st = (op_reg == dhkv_pkg::OP_SET) ? dhkv_pkg::STAT_FULL
                                                          : dhkv_pkg::STAT_NOT_FOUND;
                end
                else
                begin
                    h_next   = step;
                    rd_en    = 1'b1;
                    rd_addr  = step;
                    cnt_next = cnt_reg + dhkv_pkg::SLOT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next = out_free ? ST_IDLE : ST_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            log_cfg_reg   <= dhkv_pkg::LOG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (cfg_wr_en)
            begin
                log_cfg_reg <= cfg_wr_data;
            end
            if ((fin || state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        h_reg      <= h_next;
        stride_reg <= stride_next;
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg  <= s_axis_tuser;
            key_reg <= s_axis_tdata[31:0];
            val_reg <= s_axis_tdata[63:32];
        end
        if (fin && out_free)
        begin
            out_val_reg <= fin_val;
            out_st_reg  <= fin_st;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            out_val_reg <= res_val_reg;
            out_st_reg  <= res_st_reg;
        end
        // hold a finished result while the output is stalled
        if (fin && !out_free)
        begin
            res_val_reg <= fin_val;
            res_st_reg  <= fin_st;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!key_we && !val_we))
        else $error("slot memory written while idle");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> (cnt_reg <= mask))
        else $error("probe count beyond slot count");

    a_accept_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_HASH))
        else $error("accepted item not hashed");

    a_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> m_axis_tvalid)
        else $error("held result without a pending output");
`endif

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the double-hash key/value table core
// Streams set/get/remove items into the core and predicts each reply with
// a behavioural copy of the table. Replies are checked in order. The table
// size is swept across the legal range and beyond, while the bench changes
// how often the input side idles and the output side stalls.
// ----------------------------------------------------------------------------
module tb;

    import dhkv_pkg::*;

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int MAX_ERR_LINES  = 40;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } table_req_t;

    typedef struct packed {
        logic [VAL_W-1:0]  found;
        logic [STAT_W-1:0] status;
    } table_reply_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [OP_W-1:0]      s_axis_tuser;    // [1:0] op
    logic [63:0]          s_axis_tdata;    // [31:0] key, [63:32] value
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [STAT_W-1:0]    m_axis_tuser;    // [1:0] status
    logic [31:0]          m_axis_tdata;    // [31:0] found_value
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;

    // table copy used for prediction
    logic [KEY_W-1:0]     shadow_keys [SLOTS];
    logic [VAL_W-1:0]     shadow_vals [SLOTS];
    logic [CFG_W-1:0]     shadow_log2;

    table_req_t           pending_reqs [$];
    table_reply_t         expected_replies [$];
    table_req_t           req_on_bus;
    logic [KEY_W-1:0]     key_pool [$];

    int                   src_idle_pct = 0;
    int                   snk_stall_pct = 0;
    int                   err_count = 0;
    int                   reqs_taken = 0;
    int                   replies_seen = 0;
    int                   full_seen = 0;
    int                   miss_seen = 0;
    int                   hit_seen = 0;
    int                   idle_cycles = 0;

    double_hash_key_value_table_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_ERR_LINES)
            $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    // Apply one operation to the table copy and return the reply it gives.
    function automatic table_reply_t apply_table_op(input table_req_t req);
        table_reply_t rep;
        logic [31:0]  lg, size, mask, k, frac, h, stride, prod;
        logic         done;
        int unsigned  i;
        lg = shadow_log2;
        if (lg < 2)
            lg = 2;
        if (lg > SLOT_W)
            lg = SLOT_W;
        size = 32'd1 << lg;
        mask = size - 32'd1;
        k = req.key >> 2;
        prod = k * 32'(GOLDEN_MULT);
        frac = prod & ((32'd1 << FRAC_W) - 32'd1);
        h = ((size * frac) >> FRAC_W) & mask;
        prod = k * STRIDE_MULT;
        stride = (prod & mask) | 32'd1;
        rep.found = '0;
        rep.status = STAT_OK;
        done = 1'b0;
        if (req.op == OP_SET)
        begin
            rep.status = STAT_FULL;
            for (i = 0; i < size && !done; i++)
            begin
                if (shadow_vals[h] == '0 || shadow_keys[h] == req.key)
                begin
                    shadow_keys[h] = req.key;
                    shadow_vals[h] = req.value;
                    rep.status = STAT_OK;
                    done = 1'b1;
                end
                else
                    h = (h + stride) & mask;
            end
        end
        else if (req.op == OP_GET || req.op == OP_REMOVE)
        begin
            rep.status = STAT_NOT_FOUND;
            for (i = 0; i < size && !done; i++)
            begin
                if (shadow_keys[h] == '0)
                    done = 1'b1;
                else if (shadow_keys[h] == req.key)
                begin
                    if (req.op == OP_GET)
                    begin
                        rep.found = shadow_vals[h];
                        rep.status = (rep.found != '0) ? STAT_OK : STAT_NOT_FOUND;
                    end
                    else
                    begin
                        shadow_vals[h] = '0;
                        rep.status = STAT_OK;
                    end
                    done = 1'b1;
                end
                else
                    h = (h + stride) & mask;
            end
        end
        return rep;
    endfunction

    // Input side: hold an item until taken, then predict its reply.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tuser  <= '0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_replies.push_back(apply_table_op(req_on_bus));
                reqs_taken++;
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // hold the item until it is taken
            end
            else if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                req_on_bus = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= req_on_bus.op;
                s_axis_tdata  <= {req_on_bus.value, req_on_bus.key};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Output side: compare each reply with the oldest prediction.
    always @(posedge clk)
    begin
        table_reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            replies_seen++;
            if (m_axis_tuser == STAT_FULL)
                full_seen++;
            else if (m_axis_tuser == STAT_NOT_FOUND)
                miss_seen++;
            else
                hit_seen++;
            if (expected_replies.size() == 0)
                report_mismatch($sformatf("unexpected reply value=%h status=%0d",
                                          m_axis_tdata, m_axis_tuser));
            else
            begin
                want = expected_replies.pop_front();
                if (m_axis_tdata !== want.found)
                    report_mismatch($sformatf("reply %0d: found_value %h, want %h",
                                              replies_seen, m_axis_tdata, want.found));
                if (m_axis_tuser !== want.status)
                    report_mismatch($sformatf("reply %0d: status %0d, want %0d",
                                              replies_seen, m_axis_tuser, want.status));
            end
        end
    end

    // Stop the run when neither side has moved an item for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic push_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                            input logic [VAL_W-1:0] value);
        table_req_t r;
        r.op = op;
        r.key = key;
        r.value = value;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_replies.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_table_log2(input logic [CFG_W-1:0] lg);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lg;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_log2 = lg;
    endtask

    function automatic table_req_t random_req();
        table_req_t  r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45)
            r.op = OP_SET;
        else if (pick < 75)
            r.op = OP_GET;
        else if (pick < 95)
            r.op = OP_REMOVE;
        else
            r.op = OP_NONE;
        pick = $urandom_range(99);
        if (pick < 75)
            r.key = key_pool[$urandom_range(key_pool.size() - 1)];
        else if (pick < 77)
            r.key = '0;
        else
            r.key = $urandom;
        r.value = ($urandom_range(99) < 5) ? '0 : VAL_W'($urandom);
        return r;
    endfunction

    initial
    begin
        int          phase_cfg [8];
        int          phase_len [8];
        int          pool_n;
        int          p;
        int          n;
        int          mode;
        table_req_t  r;

        for (int j = 0; j < SLOTS; j++)
        begin
            shadow_keys[j] = '0;
            shadow_vals[j] = '0;
        end
        shadow_log2 = LOG_RESET;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Smallest table: fill it, overflow it, then exercise deletes and key 0.
        write_table_log2(CFG_W'(2));
        push_req(OP_GET,    32'h0000_0001, 32'h0);
        push_req(OP_REMOVE, 32'h0000_0005, 32'h0);
        push_req(OP_SET,    32'h0000_0004, 32'hFFFF_FFFF);
        push_req(OP_SET,    32'hFFFF_FFFF, 32'h0000_0001);
        push_req(OP_SET,    32'h0000_0008, 32'h0000_0005);
        push_req(OP_SET,    32'h0000_000C, 32'h0000_0006);
        push_req(OP_SET,    32'h0000_0010, 32'h0000_0007);
        push_req(OP_GET,    32'h0000_0010, 32'h0);
        push_req(OP_REMOVE, 32'h0000_0010, 32'h0);
        push_req(OP_GET,    32'h0000_0004, 32'h0);
        push_req(OP_SET,    32'h0000_0004, 32'h0000_0009);
        push_req(OP_REMOVE, 32'h0000_0008, 32'h0);
        push_req(OP_GET,    32'h0000_0008, 32'h0);
        push_req(OP_SET,    32'h0000_0014, 32'h0000_0003);
        push_req(OP_SET,    32'h0000_000C, 32'h0);
        push_req(OP_GET,    32'h0000_000C, 32'h0);
        push_req(OP_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(OP_GET,    32'h0000_0000, 32'h0);
        push_req(OP_SET,    32'h0000_0000, 32'h0000_0005);
        push_req(OP_GET,    32'h0000_0000, 32'h0);
        push_req(OP_REMOVE, 32'h0000_0000, 32'h0);
        wait_drained();

        write_table_log2(CFG_W'(SLOT_W));
        push_req(OP_SET,    32'hFFFF_FFFF, 32'hAAAA_AAAA);
        push_req(OP_GET,    32'hFFFF_FFFF, 32'h0);
        push_req(OP_GET,    32'h8000_0000, 32'h0);
        wait_drained();

        // Table sizes swept, including values outside the legal range.
        phase_cfg = '{15, 2, 0, 3, 6, 1, $urandom_range(4, 9), 10};
        phase_len = '{200, 160, 160, 180, 200, 160, 180, 160};

        for (p = 0; p < 8; p++)
        begin
            write_table_log2(CFG_W'(phase_cfg[p]));
            mode = p % 4;
            src_idle_pct  = (mode == 1) ? 48 : (mode == 3) ? 21 : 0;
            snk_stall_pct = (mode == 2) ? 48 : (mode == 3) ? 21 : 0;
            key_pool.delete();
            pool_n = $urandom_range(8, 40);
            for (n = 0; n < pool_n; n++)
                key_pool.push_back(($urandom | 32'h1) ^ (32'(n) << 2));
            for (n = 0; n < phase_len[p]; n++)
            begin
                r = random_req();
                pending_reqs.push_back(r);
                // in phase 4, let the core empty out completely halfway through
                if (p == 4 && n == phase_len[p] / 2)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (64) @(posedge clk);

        $display("covered %0d items over %0d table-size settings and four idle patterns",
                 reqs_taken, 10);
        $display("replies: %0d ok, %0d not found, %0d table full",
                 hit_seen, miss_seen, full_seen);
        if (err_count == 0 && expected_replies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
